// ===== rtl/smpq_pkg.sv =====
// shared types and codes for the stable max priority queue
`timescale 1ns / 1ps
package smpq_pkg;

    localparam int unsigned TAG_W    = 16;
    localparam int unsigned SEV_W    = 16;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned ENTRY_W  = TAG_W + SEV_W + SEQ_W;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SERVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

// ===== rtl/stable_max_priority_queue.sv =====
// Bounded max priority queue: highest severity served first, earliest arrival wins a tie.
// Input channel: i_in_valid / o_in_stall carry one command (insert, serve, clear).
// Output channel: o_out_valid / i_out_stall carry one result per command;
// mode 3 is taken and gives no result.
// Entries sit in one single-port-write, registered-read memory in arrival order.
// Insert and clear finish at the transfer: the result is in the output register
// on the next cycle, one command per cycle while the receiver keeps up.
// Serve with n entries walks the memory through one severity comparator,
// one entry per cycle, then closes the gap left by the served entry
// by moving each later entry down one place, one per cycle, and a last
// step loads the result into the output register once that register is free.
// The memory read and write ports set this pace.
// Serve on an empty queue and insert into a full one are flagged in status.
// Reset (synchronous, active low) empties the queue, restarts the sequence and
// drops any pending result; the memory itself is not cleared.
// While the receiver stalls, the result is held and a new command is taken only
// once the output register is free or being drained in that cycle.
`timescale 1ns / 1ps
module stable_max_priority_queue #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [smpq_pkg::MODE_W-1:0]    i_mode,
    input  logic [smpq_pkg::TAG_W-1:0]     i_patient_tag,
    input  logic [smpq_pkg::SEV_W-1:0]     i_severity,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [smpq_pkg::STATUS_W-1:0]  o_status,
    output logic [smpq_pkg::TAG_W-1:0]     o_served_tag,
    output logic [smpq_pkg::SEV_W-1:0]     o_served_severity
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [smpq_pkg::ENTRY_W-1:0] r_mem [CAPACITY];
    logic [smpq_pkg::ENTRY_W-1:0] r_rd;

    smpq_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [smpq_pkg::SEQ_W-1:0] r_seq, n_seq;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic [smpq_pkg::SEV_W-1:0] r_best_sev, n_best_sev;
    logic [smpq_pkg::TAG_W-1:0] r_best_tag, n_best_tag;

    logic                          r_out_valid, n_out_valid;
    logic [smpq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [smpq_pkg::TAG_W-1:0]    r_out_tag, n_out_tag;
    logic [smpq_pkg::SEV_W-1:0]    r_out_sev, n_out_sev;

    logic                          w_out_free;
    logic                          w_accept;
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic [smpq_pkg::ENTRY_W-1:0]  w_wr_data;
    logic [AW-1:0]                 w_rd_addr;
    logic [smpq_pkg::SEV_W-1:0]    w_rd_sev;
    logic [smpq_pkg::TAG_W-1:0]    w_rd_tag;
    logic                          w_take;
    logic [CW-1:0]                 w_after_best;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == smpq_pkg::S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_rd_tag    = r_rd[smpq_pkg::TAG_W-1:0];
    assign w_rd_sev    = r_rd[smpq_pkg::TAG_W +: smpq_pkg::SEV_W];

    // strict greater keeps the earliest of equal severities
    assign w_take       = (r_ptr == '0) || (w_rd_sev > r_best_sev);
    assign w_after_best = CW'(n_best_idx) + ONE_C;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_served_tag      = r_out_tag;
    assign o_served_severity = r_out_sev;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_ptr       = r_ptr;
        n_seq       = r_seq;
        n_best_idx  = r_best_idx;
        n_best_sev  = r_best_sev;
        n_best_tag  = r_best_tag;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_out_tag   = r_out_tag;
        n_out_sev   = r_out_sev;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_occ[AW-1:0];
        w_wr_data   = {r_seq, i_severity, i_patient_tag};
        w_rd_addr   = '0;

        case (r_state)
            smpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_tag = '0;
                    n_out_sev = '0;
                    case (i_mode)
                        smpq_pkg::MODE_INSERT: begin
                            n_out_valid = 1'b1;
                            if (r_occ == CAP_C) begin
                                n_status = smpq_pkg::ST_FULL;
                            end else begin
                                n_status = smpq_pkg::ST_INSERTED;
                                w_wr_en  = 1'b1;
                                n_occ    = r_occ + ONE_C;
                                n_seq    = r_seq + 32'd1;
                            end
                        end
                        smpq_pkg::MODE_SERVE: begin
                            if (r_occ == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = smpq_pkg::ST_EMPTY;
                            end else begin
                                // entry 0 is read at this transfer
                                n_state = smpq_pkg::S_SCAN;
                                n_ptr   = '0;
                            end
                        end
                        smpq_pkg::MODE_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_status    = smpq_pkg::ST_CLEARED;
                            n_occ       = '0;
                            n_seq       = '0;
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    endcase
                end
            end
            smpq_pkg::S_SCAN: begin
                // r_rd holds the entry at r_ptr
                if (w_take) begin
                    n_best_idx = r_ptr[AW-1:0];
                    n_best_sev = w_rd_sev;
                    n_best_tag = w_rd_tag;
                end
                if (r_ptr == r_occ - ONE_C) begin
                    n_state   = smpq_pkg::S_SHIFT;
                    n_ptr     = w_after_best;
                    w_rd_addr = w_after_best[AW-1:0];
                end else begin
                    n_ptr     = r_ptr + ONE_C;
                    w_rd_addr = n_ptr[AW-1:0];
                end
            end
            smpq_pkg::S_SHIFT: begin
                // r_rd holds the entry at r_ptr, which moves down one place
                if (r_ptr == r_occ) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = smpq_pkg::ST_SERVED;
                        n_out_tag   = r_best_tag;
                        n_out_sev   = r_best_sev;
                        n_occ       = r_occ - ONE_C;
                        n_state     = smpq_pkg::S_IDLE;
                    end
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = AW'(r_ptr - ONE_C);
                    w_wr_data = r_rd;
                    n_ptr     = r_ptr + ONE_C;
                    w_rd_addr = n_ptr[AW-1:0];
                end
            end
            default: begin
                n_state = smpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smpq_pkg::S_IDLE;
            r_occ       <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_best_idx <= n_best_idx;
        r_best_sev <= n_best_sev;
        r_best_tag <= n_best_tag;
        r_status   <= n_status;
        r_out_tag  <= n_out_tag;
        r_out_sev  <= n_out_sev;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

endmodule
